@@ rtl/core/jdst_pkg.sv @@
// Shared types, constants and helper functions for the Julian date / sidereal time core.
`default_nettype none
package jdst_pkg;

  // Field and register widths
  localparam int JD_W     = 54;
  localparam int LON_W    = 41;
  localparam int OFS_W    = 41;
  localparam int RATE_W   = 49;
  localparam int SQ_W     = 48;
  localparam int CDIV_W   = 32;
  localparam int SID_W    = 42;
  localparam int CFG_W    = 54;
  localparam int IDX_W    = 3;

  // Internal widths: Q.80 degree sum, cube product, divider numerator
  localparam int SUM_W      = 113;
  localparam int CUBE_W     = 85;
  localparam int DIV_W      = 88;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = DIV_W / DIV_STEP;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_LONGITUDE = 3'd0,
    REG_EPOCH     = 3'd1,
    REG_OFFSET    = 3'd2,
    REG_RATE      = 3'd3,
    REG_SQUARE    = 3'd4,
    REG_CUBE_DIV  = 3'd5
  } cfg_reg_t;

  localparam logic [JD_W-1:0]  EPOCH_RESET = 54'd10529305599672320;
  localparam logic [SID_W-1:0] SID_LIMIT   = 42'd1546188226560;

  // Constant divisors and their 2^32 reciprocals (floor)
  localparam logic [31:0] DIV_SECS    = 32'd675;
  localparam logic [31:0] RCP_SECS    = 32'd6362914;
  localparam logic [31:0] DIV_CENT    = 32'd100;
  localparam logic [31:0] RCP_CENT    = 32'd42949672;
  localparam logic [31:0] DIV_JCENT   = 32'd36525;
  localparam logic [31:0] RCP_JCENT   = 32'd117589;
  localparam logic [31:0] DIV_CIRCLE  = 32'd360;
  localparam logic [31:0] RCP_CIRCLE  = 32'd11930464;

  // Configuration register set
  typedef struct packed {
    logic [LON_W-1:0]  longitude;
    logic [JD_W-1:0]   epoch;
    logic [OFS_W-1:0]  offset;
    logic [RATE_W-1:0] rate;
    logic [SQ_W-1:0]   square;
    logic [CDIV_W-1:0] cube_div;
  } cfg_t;

  // Beat leaving the polynomial pipe
  typedef struct packed {
    logic [SUM_W-1:0]  s0;
    logic [CUBE_W-1:0] cube;
    logic [JD_W-1:0]   jd;
    logic              dneg;
  } poly_t;

  // Beat leaving the cube divider
  typedef struct packed {
    logic [SUM_W-1:0]  s0;
    logic [CUBE_W-1:0] quot;
    logic [JD_W-1:0]   jd;
    logic              dneg;
  } quot_t;

  typedef struct packed {
    logic [31:0] q;
    logic [31:0] r;
  } cdiv_t;

  // Divide by a constant via reciprocal multiply plus one correction step.
  // Exact for x below 2^32 when recip = floor(2^32 / dc).
  function automatic cdiv_t cdiv(input logic [31:0] x, input logic [31:0] dc,
                                 input logic [31:0] recip);
    logic [63:0] prod;
    cdiv_t       o;
    prod = {32'd0, x} * {32'd0, recip};
    o.q  = prod[63:32];
    o.r  = x - o.q * dc;
    if (o.r >= dc) begin
      o.q = o.q + 32'd1;
      o.r = o.r - dc;
    end
    return o;
  endfunction

  // floor(30.6001 * month number); Jan/Feb count as months 14/15
  function automatic logic [9:0] month_days(input logic [3:0] mon);
    logic [9:0] v;
    case (mon)
      4'd0:    v = 10'd428;
      4'd1:    v = 10'd459;
      4'd2:    v = 10'd122;
      4'd3:    v = 10'd153;
      4'd4:    v = 10'd183;
      4'd5:    v = 10'd214;
      4'd6:    v = 10'd244;
      4'd7:    v = 10'd275;
      4'd8:    v = 10'd306;
      4'd9:    v = 10'd336;
      4'd10:   v = 10'd367;
      4'd11:   v = 10'd397;
      4'd12:   v = 10'd428;
      4'd13:   v = 10'd459;
      4'd14:   v = 10'd489;
      4'd15:   v = 10'd520;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/jdst_julian.sv @@
// Four-stage pipe turning a broken-down UTC timestamp into a Q22.32 Julian date.
`default_nettype none
module jdst_julian (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     adv,
  input  logic                     in_valid,
  input  logic [9:0]               year_since_1900,
  input  logic [3:0]               month_index,
  input  logic [4:0]               day_of_month,
  input  logic [4:0]               hour,
  input  logic [5:0]               minute,
  input  logic [5:0]               second,
  output logic                     out_valid,
  output logic [jdst_pkg::JD_W-1:0] jd
);
  import jdst_pkg::*;

  logic [3:0] v;

  // stage 1
  logic [11:0] yy1;
  logic [9:0]  x2_1;
  logic [4:0]  day1;
  logic [7:0]  qs1;
  logic [9:0]  rs1;
  // stage 2
  logic [21:0] x1_2;
  logic [4:0]  a2;
  logic [9:0]  x2_2;
  logic [4:0]  day2;
  logic [7:0]  qs2;
  logic [11:0] q2_2;
  logic [9:0]  r2_2;
  // stage 3
  logic [21:0] days3;
  logic [32:0] frac3;
  // stage 4
  logic [JD_W-1:0] jd4;

  logic [16:0] secs;
  logic [11:0] yy;
  cdiv_t       d1, d2, d3, dc;
  logic [12:0] yy4716;
  logic [23:0] x1p;
  logic [23:0] days;

  // seconds of day, shifted year, first day-fraction digit
  assign secs = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
  assign yy   = (month_index < 4'd2) ? 12'(year_since_1900) + 12'd1899
                                     : 12'(year_since_1900) + 12'd1900;
  assign d1   = cdiv(32'(secs), DIV_SECS, RCP_SECS);

  // year term, century, second fraction digit
  assign yy4716 = 13'(yy1) + 13'd4716;
  assign x1p    = 24'(yy4716) * 24'd1461;
  assign dc     = cdiv(32'(yy1), DIV_CENT, RCP_CENT);
  assign d2     = cdiv({10'd0, rs1, 12'd0}, DIV_SECS, RCP_SECS);

  // day count with Gregorian correction, last fraction digit (+337 = rounding half)
  assign days = 24'(x1_2) + 24'(x2_2) + 24'(day2) + 24'(a2[4:2]) + 24'd2
              - 24'(a2) - 24'd1525;
  assign d3   = cdiv({9'd0, r2_2, 13'd337}, DIV_SECS, RCP_SECS);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      yy1   <= yy;
      x2_1  <= month_days(month_index);
      day1  <= day_of_month;
      qs1   <= d1.q[7:0];
      rs1   <= d1.r[9:0];

      x1_2  <= x1p[23:2];
      a2    <= dc.q[4:0];
      x2_2  <= x2_1;
      day2  <= day1;
      qs2   <= qs1;
      q2_2  <= d2.q[11:0];
      r2_2  <= d2.r[9:0];

      days3 <= days[21:0];
      frac3 <= {qs2, q2_2, d3.q[12:0]};

      jd4   <= {days3, 32'd0} + 54'h0_0000_8000_0000 + 54'(frac3);
    end
  end

  assign out_valid = v[3];
  assign jd        = jd4;

endmodule
`default_nettype wire

@@ rtl/core/jdst_poly.sv @@
// Nine-stage pipe: epoch offset, century count, and the linear/square/cube products.
`default_nettype none
module jdst_poly (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  jdst_pkg::cfg_t            cfg,
  input  logic                      in_valid,
  input  logic [jdst_pkg::JD_W-1:0] jd,
  output logic                      out_valid,
  output jdst_pkg::poly_t           beat
);
  import jdst_pkg::*;

  logic [8:0] v;

  // P1
  logic [JD_W-1:0] jd1, dmag1;
  logic            dneg1;
  // P2
  logic [JD_W-1:0] jd2;
  logic            dneg2;
  logic [31:0]     dmag_lo2;
  logic [51:0]     pr00, pr01;
  logic [50:0]     pr10, pr11;
  logic [6:0]      tq1_2;
  logic [15:0]     tr1_2;
  // P3
  logic [JD_W-1:0] jd3;
  logic            dneg3;
  logic [15:0]     dmag_lo3;
  logic [102:0]    rp3;
  logic [6:0]      tq1_3;
  logic [15:0]     tq2_3, tr2_3;
  // P4..P8
  logic [JD_W-1:0]  jd4, jd5, jd6, jd7, jd8;
  logic             dneg4, dneg5, dneg6, dneg7, dneg8;
  logic [SUM_W-1:0] sa4, sa5, sa6, sa7, sa8;
  logic [38:0]      t4, t5, t6;
  logic [39:0]      pll;
  logic [38:0]      plh;
  logic [37:0]      phh;
  logic [45:0]      t2_6;
  logic [46:0]      s00, s01, s10, s11;
  logic [42:0]      c00, c10;
  logic [41:0]      c01, c11;
  logic [93:0]      sq8;
  logic [CUBE_W-1:0] cube8;

  logic             dneg;
  cdiv_t            dt1, dt2, dt3;
  logic [SUM_W-1:0] rterm, sa;
  logic [77:0]      tt;

  // signed distance from the epoch
  assign dneg = jd < cfg.epoch;

  // centuries: three 16-bit long-division digits by 36525
  assign dt1 = cdiv({10'd0, dmag1[53:32]}, DIV_JCENT, RCP_JCENT);
  assign dt2 = cdiv({tr1_2, dmag_lo2[31:16]}, DIV_JCENT, RCP_JCENT);
  assign dt3 = cdiv({tr2_3, dmag_lo3}, DIV_JCENT, RCP_JCENT);

  // offset, signed rate term and negated longitude in Q.80
  assign rterm = {2'd0, rp3, 8'd0};
  assign sa = {24'd0, cfg.offset, 48'd0} + (dneg3 ? (113'd0 - rterm) : rterm)
            - {{24{cfg.longitude[LON_W-1]}}, cfg.longitude, 48'd0};

  // T squared
  assign tt = 78'(pll) + (78'(plh) << 21) + (78'(phh) << 40);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[7:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // P1
      jd1   <= jd;
      dneg1 <= dneg;
      dmag1 <= dneg ? cfg.epoch - jd : jd - cfg.epoch;
      // P2: rate partial products, first century digit
      jd2      <= jd1;
      dneg2    <= dneg1;
      dmag_lo2 <= dmag1[31:0];
      pr00     <= 52'(cfg.rate[24:0]) * 52'(dmag1[26:0]);
      pr01     <= 52'(cfg.rate[24:0]) * 52'(dmag1[53:27]);
      pr10     <= 51'(cfg.rate[48:25]) * 51'(dmag1[26:0]);
      pr11     <= 51'(cfg.rate[48:25]) * 51'(dmag1[53:27]);
      tq1_2    <= dt1.q[6:0];
      tr1_2    <= dt1.r[15:0];
      // P3
      jd3      <= jd2;
      dneg3    <= dneg2;
      dmag_lo3 <= dmag_lo2[15:0];
      rp3      <= 103'(pr00) + (103'(pr01) << 27) + (103'(pr10) << 25) + (103'(pr11) << 52);
      tq1_3    <= tq1_2;
      tq2_3    <= dt2.q[15:0];
      tr2_3    <= dt2.r[15:0];
      // P4
      jd4   <= jd3;
      dneg4 <= dneg3;
      sa4   <= sa;
      t4    <= {tq1_3, tq2_3, dt3.q[15:0]};
      // P5: T*T partials
      jd5   <= jd4;
      dneg5 <= dneg4;
      sa5   <= sa4;
      t5    <= t4;
      pll   <= 40'(t4[19:0]) * 40'(t4[19:0]);
      plh   <= 39'(t4[19:0]) * 39'(t4[38:20]);
      phh   <= 38'(t4[38:20]) * 38'(t4[38:20]);
      // P6
      jd6   <= jd5;
      dneg6 <= dneg5;
      sa6   <= sa5;
      t6    <= t5;
      t2_6  <= tt[77:32];
      // P7: C2*T^2 and T^2*T partials
      jd7   <= jd6;
      dneg7 <= dneg6;
      sa7   <= sa6;
      s00   <= 47'(cfg.square[23:0]) * 47'(t2_6[22:0]);
      s01   <= 47'(cfg.square[23:0]) * 47'(t2_6[45:23]);
      s10   <= 47'(cfg.square[47:24]) * 47'(t2_6[22:0]);
      s11   <= 47'(cfg.square[47:24]) * 47'(t2_6[45:23]);
      c00   <= 43'(t2_6[22:0]) * 43'(t6[19:0]);
      c01   <= 42'(t2_6[22:0]) * 42'(t6[38:20]);
      c10   <= 43'(t2_6[45:23]) * 43'(t6[19:0]);
      c11   <= 42'(t2_6[45:23]) * 42'(t6[38:20]);
      // P8
      jd8   <= jd7;
      dneg8 <= dneg7;
      sa8   <= sa7;
      sq8   <= 94'(s00) + (94'(s01) << 23) + (94'(s10) << 24) + (94'(s11) << 47);
      cube8 <= 85'(c00) + (85'(c01) << 20) + (85'(c10) << 23) + (85'(c11) << 43);
      // P9
      beat.s0   <= sa8 + {19'd0, sq8};
      beat.cube <= cube8;
      beat.jd   <= jd8;
      beat.dneg <= dneg8;
    end
  end

  assign out_valid = v[8];

endmodule
`default_nettype wire

@@ rtl/core/jdst_cubediv.sv @@
// Pipelined restoring divider for the cubic term, four quotient bits per stage.
`default_nettype none
module jdst_cubediv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        adv,
  input  logic [jdst_pkg::CDIV_W-1:0] dsor_raw,
  input  logic                        in_valid,
  input  jdst_pkg::poly_t             in_beat,
  output logic                        out_valid,
  output jdst_pkg::quot_t             out_beat
);
  import jdst_pkg::*;

  typedef struct packed {
    logic [DIV_W-1:0]  nq;
    logic [CDIV_W-1:0] rem;
    logic [SUM_W-1:0]  s0;
    logic [JD_W-1:0]   jd;
    logic              dneg;
  } dstage_t;

  dstage_t               st  [DIV_STAGES];
  dstage_t               nxt [DIV_STAGES];
  dstage_t               head;
  logic [DIV_STAGES-1:0] v;
  logic [CDIV_W-1:0]     dsor;

  // One stage's worth of shift / compare / subtract
  function automatic dstage_t div_step(input dstage_t a, input logic [CDIV_W-1:0] d);
    logic [CDIV_W:0] r;
    dstage_t         o;
    o = a;
    for (int i = 0; i < DIV_STEP; i++) begin
      r    = {o.rem, o.nq[DIV_W-1]};
      o.nq = {o.nq[DIV_W-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r       = r - {1'b0, d};
        o.nq[0] = 1'b1;
      end
      o.rem = r[CDIV_W-1:0];
    end
    return o;
  endfunction

  // zero divisor acts as one
  assign dsor = (dsor_raw == '0) ? CDIV_W'(1) : dsor_raw;

  always_comb begin
    head.nq   = DIV_W'(in_beat.cube);
    head.rem  = '0;
    head.s0   = in_beat.s0;
    head.jd   = in_beat.jd;
    head.dneg = in_beat.dneg;
    nxt[0] = div_step(head, dsor);
    for (int k = 1; k < DIV_STAGES; k++) begin
      nxt[k] = div_step(st[k-1], dsor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[DIV_STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  assign out_valid     = v[DIV_STAGES-1];
  assign out_beat.s0   = st[DIV_STAGES-1].s0;
  assign out_beat.quot = st[DIV_STAGES-1].nq[CUBE_W-1:0];
  assign out_beat.jd   = st[DIV_STAGES-1].jd;
  assign out_beat.dneg = st[DIV_STAGES-1].dneg;

  // partial remainder stays below the divisor
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v[0] |-> (st[0].rem < dsor))
    else $error("cube divider remainder out of range");

  // quotient of a value below 2^85 has no high bits
  a_quot_width: assert property (@(posedge clk) disable iff (rst)
    v[DIV_STAGES-1] |-> (st[DIV_STAGES-1].nq[DIV_W-1:CUBE_W] == '0))
    else $error("cube quotient overflow");

endmodule
`default_nettype wire

@@ rtl/core/jdst_reduce.sv @@
// Final sum, magnitude, modulo-360 reduction and result register.
`default_nettype none
module jdst_reduce (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              adv,
  input  logic                              in_valid,
  input  jdst_pkg::quot_t                   in_beat,
  output logic                              out_valid,
  output logic [jdst_pkg::JD_W-1:0]         julian_date,
  output logic signed [jdst_pkg::SID_W-1:0] sidereal_deg
);
  import jdst_pkg::*;

  logic [2:0] v;

  logic [SUM_W-1:0] s1;
  logic [JD_W-1:0]  jd1, jd2, jd3;
  logic             sneg2;
  logic [31:0]      hi2, mid2;
  logic [SID_W-1:0] sid3;

  logic [SUM_W-1:0] term, ssum, mag;
  cdiv_t            dm;
  logic [SID_W-1:0] val;

  // cubic term enters with the opposite sign of d
  assign term = {12'd0, in_beat.quot, 16'd0};
  assign ssum = in_beat.s0 + (in_beat.dneg ? term : (113'd0 - term));

  // magnitude of the Q.80 sum
  assign mag = s1[SUM_W-1] ? (113'd0 - s1) : s1;

  // whole degrees mod 360, fraction kept to Q.32
  assign dm  = cdiv(hi2, DIV_CIRCLE, RCP_CIRCLE);
  assign val = {1'b0, dm.r[8:0], mid2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1    <= ssum;
      jd1   <= in_beat.jd;
      sneg2 <= s1[SUM_W-1];
      hi2   <= mag[111:80];
      mid2  <= mag[79:48];
      jd2   <= jd1;
      sid3  <= sneg2 ? (42'd0 - val) : val;
      jd3   <= jd2;
    end
  end

  assign out_valid    = v[2];
  assign julian_date  = jd3;
  assign sidereal_deg = $signed(sid3);

endmodule
`default_nettype wire

@@ rtl/core/julian_date_sidereal_time_core.sv @@
// Top level of the Julian date and local sidereal time core.
// Takes one UTC timestamp per beat and returns its Q22.32 Julian date and the
// local sidereal time in signed Q9.32 degrees (C0 + C1*d + C2*T^2 - T^3/C3 -
// longitude, remainder mod 360 truncated toward zero). A beat can enter every
// clock while item_stall is low; each timestamp passes through 4 stages
// of calendar math, 9 of products, 22 of the pipelined cube divider (four
// quotient bits per stage over an 88-bit numerator) and 3 of reduction. The
// whole pipe freezes while a waiting result is stalled. Registers are plain
// writes, to be done while no beat is in flight.
`default_nettype none
module julian_date_sidereal_time_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [9:0]                        year_since_1900,
  input  logic [3:0]                        month_index,
  input  logic [4:0]                        day_of_month,
  input  logic [4:0]                        hour,
  input  logic [5:0]                        minute,
  input  logic [5:0]                        second,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic [jdst_pkg::JD_W-1:0]         julian_date,
  output logic signed [jdst_pkg::SID_W-1:0] sidereal_deg,
  input  logic                              cfg_write,
  input  logic [jdst_pkg::IDX_W-1:0]        cfg_index,
  input  logic [jdst_pkg::CFG_W-1:0]        cfg_data
);
  import jdst_pkg::*;

  cfg_t            cfg;
  logic            adv;
  logic            jd_valid, poly_valid, quot_valid;
  logic [JD_W-1:0] jd;
  poly_t           poly_beat;
  quot_t           quot_beat;

  // pipe moves unless the result register is full and stalled
  assign adv        = !result_valid || !result_stall;
  assign item_stall = !adv;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.longitude <= '0;
      cfg.epoch     <= EPOCH_RESET;
      cfg.offset    <= '0;
      cfg.rate      <= '0;
      cfg.square    <= '0;
      cfg.cube_div  <= CDIV_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_LONGITUDE: cfg.longitude <= cfg_data[LON_W-1:0];
        REG_EPOCH:     cfg.epoch     <= cfg_data[JD_W-1:0];
        REG_OFFSET:    cfg.offset    <= cfg_data[OFS_W-1:0];
        REG_RATE:      cfg.rate      <= cfg_data[RATE_W-1:0];
        REG_SQUARE:    cfg.square    <= cfg_data[SQ_W-1:0];
        REG_CUBE_DIV:  cfg.cube_div  <= cfg_data[CDIV_W-1:0];
        default:       ;
      endcase
    end
  end

  jdst_julian u_julian (
    .clk             (clk),
    .rst             (rst),
    .adv             (adv),
    .in_valid        (item_valid),
    .year_since_1900 (year_since_1900),
    .month_index     (month_index),
    .day_of_month    (day_of_month),
    .hour            (hour),
    .minute          (minute),
    .second          (second),
    .out_valid       (jd_valid),
    .jd              (jd)
  );

  jdst_poly u_poly (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .cfg       (cfg),
    .in_valid  (jd_valid),
    .jd        (jd),
    .out_valid (poly_valid),
    .beat      (poly_beat)
  );

  jdst_cubediv u_cubediv (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .dsor_raw  (cfg.cube_div),
    .in_valid  (poly_valid),
    .in_beat   (poly_beat),
    .out_valid (quot_valid),
    .out_beat  (quot_beat)
  );

  jdst_reduce u_reduce (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .in_valid     (quot_valid),
    .in_beat      (quot_beat),
    .out_valid    (result_valid),
    .julian_date  (julian_date),
    .sidereal_deg (sidereal_deg)
  );

  // sidereal time stays inside one turn either side of zero
  a_sid_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (sidereal_deg[SID_W-1] ? ((42'd0 - sidereal_deg) < SID_LIMIT)
                                            : (sidereal_deg < SID_LIMIT)))
    else $error("sidereal time outside one turn");

  // any timestamp from 1900 on lands past JD 2415000
  a_jd_floor: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (julian_date[JD_W-1:32] >= 22'd2415000))
    else $error("julian date below calendar floor");

endmodule
`default_nettype wire
